@@ src/smbx_pkg.sv @@
// types and constants for the service mailbox with ready list
// no dependencies
`timescale 1ns / 1ps
package smbx_pkg;
	localparam int unsigned REQ_W = 3;
	localparam int unsigned QID_W = 3;
	localparam int unsigned CNT_W = 10;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH     = 3'd0,
		REQ_SCHEDULE = 3'd1,
		REQ_NEXT     = 3'd2,
		REQ_POP      = 3'd3,
		REQ_LENGTH   = 3'd4,
		REQ_TAKE_OVL = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic REG_CONCURRENT = 1'b0;
	localparam logic REG_OVL_BASE   = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [QID_W-1:0] queue_id;
		logic [63:0]      payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [63:0]      msg_out;
		logic [QID_W-1:0] ready_id;
		logic [CNT_W-1:0] count;
		logic             became_ready;
	} out_item_t;
endpackage

@@ src/smbx_ram.sv @@
// generic single-port-write, single-read synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
module smbx_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/service_mailbox_with_ready_list_top.sv @@
// service mailbox with ready list: per-queue ring mailboxes in one ram
// sequence: idle accepts a request, read registers the result, out loads the output register;
// a non-empty pop visits the overload check state between read and out, staying there while
// the limit doubles; a stalled output holds the request in place; no new request until idle
// reset: pointers and overload values cleared, marks set, limits at the reset base of 256
// depends on smbx_pkg and smbx_ram
`timescale 1ns / 1ps
module service_mailbox_with_ready_list_top
	import smbx_pkg::*;
#(
	parameter int unsigned NUM_QUEUES   = 8,
	parameter int unsigned QUEUE_DEPTH  = 1024,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int unsigned DW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW    = QW + 1;
	localparam int unsigned LIM_W = (DW + 2 > 11) ? DW + 2 : 11;
	localparam int unsigned AW    = $clog2(NUM_QUEUES * QUEUE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_OVL  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	function automatic logic [QW-1:0] queue_of(logic [QID_W-1:0] id);
		logic [QID_W:0] v;
		v = {1'b0, id};
		for (int k = 0; k < 4; k++) begin
			if (32'(v) >= NUM_QUEUES) v = v - (QID_W+1)'(NUM_QUEUES);
		end
		return QW'(v);
	endfunction

	function automatic logic [QW-1:0] slot_next(logic [QW-1:0] s);
		return (32'(s) == NUM_QUEUES - 1) ? '0 : s + QW'(1);
	endfunction

	function automatic logic [DW-1:0] idx_next(logic [DW-1:0] x);
		return (32'(x) == QUEUE_DEPTH - 1) ? '0 : x + DW'(1);
	endfunction

	function automatic logic [DW-1:0] ring_len(logic [DW-1:0] w, logic [DW-1:0] r);
		return (w >= r) ? w - r : w + DW'(QUEUE_DEPTH) - r;
	endfunction

	function automatic logic [AW-1:0] store_addr(logic [QW-1:0] q, logic [DW-1:0] x);
		return AW'(q) * AW'(QUEUE_DEPTH) + AW'(x);
	endfunction

	state_t state_q;
	logic [7:0]  conc_q;
	logic [9:0]  base_q;
	logic [REQ_W-1:0] req_q;
	logic [QW-1:0]    qid_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	logic [DW-1:0] rd_q [NUM_QUEUES];
	logic [DW-1:0] wr_q [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] mark_q;
	logic [CNT_W-1:0] ovl_q [NUM_QUEUES];
	logic [LIM_W-1:0] lim_q [NUM_QUEUES];
	logic [QW-1:0] rid_q [NUM_QUEUES];
	logic [QW-1:0] rhead_q, rtail_q;
	logic [CW-1:0] rcount_q;
	logic [DW-1:0] len_q;
	out_item_t res_q;
	out_item_t out_q;
	logic out_valid_q;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [PAYLOAD_BITS-1:0] ram_rd;

	smbx_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(pay_q),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [QW-1:0] in_q;
	logic [9:0] base_eff;
	logic [DW-1:0] rd_c, wr_c, nw_c, nr_c, len_c;
	logic rfull, conc_c, conc_h, out_load;
	logic [QW-1:0] head_id, tail_nx, head_nx;
	out_item_t res_c;

	assign in_q     = queue_of(in_data.queue_id);
	assign base_eff = (base_q == 10'd0) ? 10'd1 : base_q;
	assign rd_c     = rd_q[qid_q];
	assign wr_c     = wr_q[qid_q];
	assign nw_c     = idx_next(wr_c);
	assign nr_c     = idx_next(rd_c);
	assign len_c    = ring_len(wr_c, nr_c);
	assign rfull    = (rcount_q == CW'(NUM_QUEUES));
	assign head_id  = rid_q[rhead_q];
	assign tail_nx  = slot_next(rtail_q);
	assign head_nx  = slot_next(rhead_q);
	assign conc_c   = (32'(qid_q) < 32'd8) && conc_q[3'(qid_q)];
	assign conc_h   = (32'(head_id) < 32'd8) && conc_q[3'(head_id)];

	assign ram_we   = (state_q == S_READ) && (req_q == REQ_PUSH) && (nw_c != rd_c);
	assign ram_wa   = store_addr(qid_q, wr_c);
	assign ram_ra   = store_addr(in_q, rd_q[in_q]);

	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_OVL_BASE) ? {22'd0, base_q} : {24'd0, conc_q};

	always_comb begin
		res_c = '0;
		case (req_q)
			REQ_PUSH: begin
				if (nw_c == rd_c) res_c.status = ST_FULL;
				else if (!mark_q[qid_q] && !rfull) res_c.became_ready = 1'b1;
			end
			REQ_SCHEDULE: begin
				if (rfull) res_c.status = ST_FULL;
			end
			REQ_NEXT: begin
				if (rcount_q == '0) res_c.status = ST_EMPTY;
				else res_c.ready_id = 3'(head_id);
			end
			REQ_POP: begin
				if (rd_c != wr_c) res_c.msg_out = 64'(ram_rd);
				else res_c.status = ST_EMPTY;
			end
			REQ_LENGTH: res_c.count = CNT_W'(ring_len(wr_c, rd_c));
			REQ_TAKE_OVL: res_c.count = ovl_q[qid_q];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conc_q <= 8'd0;
			base_q <= 10'd256;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_CONCURRENT) conc_q <= pwdata[7:0];
			else if (paddr[2] == REG_OVL_BASE) base_q <= pwdata[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data.req_type;
			qid_q <= in_q;
			pay_q <= PAYLOAD_BITS'(in_data.payload);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mark_q      <= '1;
			rhead_q     <= '0;
			rtail_q     <= '0;
			rcount_q    <= '0;
			res_q       <= '0;
			out_q       <= '0;
			len_q       <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rd_q[i]  <= '0;
				wr_q[i]  <= '0;
				ovl_q[i] <= '0;
				lim_q[i] <= LIM_W'(256);
				rid_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_READ;
				end
				S_READ: begin
					res_q   <= res_c;
					state_q <= (req_q == REQ_POP && rd_c != wr_c) ? S_OVL : S_OUT;
					case (req_q)
						REQ_PUSH: begin
							if (nw_c != rd_c) begin
								wr_q[qid_q] <= nw_c;
								if (!mark_q[qid_q] && !rfull) begin
									rid_q[rtail_q] <= qid_q;
									rtail_q        <= tail_nx;
									rcount_q       <= rcount_q + CW'(1);
									mark_q[qid_q]  <= 1'b1;
								end
							end
						end
						REQ_SCHEDULE: begin
							if (!rfull) begin
								rid_q[rtail_q] <= qid_q;
								rtail_q        <= tail_nx;
								rcount_q       <= rcount_q + CW'(1);
							end
						end
						REQ_NEXT: begin
							if (rcount_q != '0) begin
								rhead_q <= head_nx;
								if (conc_h) begin
									rid_q[rtail_q] <= head_id;
									rtail_q        <= tail_nx;
								end else begin
									rcount_q <= rcount_q - CW'(1);
								end
							end
						end
						REQ_POP: begin
							if (rd_c != wr_c) begin
								rd_q[qid_q] <= nr_c;
								len_q       <= len_c;
								if (lim_q[qid_q] == '0) lim_q[qid_q] <= LIM_W'(1);
							end else begin
								lim_q[qid_q] <= LIM_W'(base_eff);
								if (!conc_c) mark_q[qid_q] <= 1'b0;
							end
						end
						REQ_TAKE_OVL: ovl_q[qid_q] <= '0;
						default: ;
					endcase
				end
				S_OVL: begin
					if (LIM_W'(len_q) > lim_q[qid_q]) begin
						ovl_q[qid_q] <= CNT_W'(len_q);
						lim_q[qid_q] <= lim_q[qid_q] << 1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ tb/sv/service_mailbox_with_ready_list_top_test.sv @@
// testbench for the service mailbox with ready list: directed and random requests,
// results checked against an in-bench mailbox predictor; depends on smbx_pkg and the top
`timescale 1ns / 1ps
module service_mailbox_with_ready_list_top_test;
	import smbx_pkg::*;

	localparam int unsigned NQ = 8;
	localparam int unsigned DEPTH = 1024;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	service_mailbox_with_ready_list_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [63:0] mbox_words [NQ*DEPTH];
	logic [9:0] rd_ptr [NQ];
	logic [9:0] wr_ptr [NQ];
	logic mark [NQ];
	logic [9:0] ovl_val [NQ];
	logic [10:0] ovl_lim [NQ];
	logic [2:0] rl_ids [NQ];
	logic [2:0] rl_head, rl_tail;
	logic [3:0] rl_cnt;
	logic [7:0] conc_mask;
	logic [9:0] ovl_base;

	out_item_t expected_results [$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 1'b0;
	bit quiet_out = 1'b0;

	function automatic bit rl_append(logic [2:0] q);
		if (rl_cnt >= NQ)
			return 1'b0;
		rl_ids[rl_tail] = q;
		rl_tail = rl_tail + 3'd1;
		rl_cnt = rl_cnt + 4'd1;
		return 1'b1;
	endfunction

	function automatic out_item_t mailbox_predict(in_item_t it);
		out_item_t r;
		logic [2:0] q;
		logic [9:0] rd, wr, len;
		r = '0;
		q = it.queue_id;
		rd = rd_ptr[q];
		wr = wr_ptr[q];
		case (it.req_type)
			REQ_PUSH: begin
				if (wr + 10'd1 == rd)
					r.status = ST_FULL;
				else begin
					mbox_words[q*DEPTH + wr] = it.payload;
					wr_ptr[q] = wr + 10'd1;
					if (!mark[q] && rl_append(q)) begin
						mark[q] = 1'b1;
						r.became_ready = 1'b1;
					end
				end
			end
			REQ_SCHEDULE: begin
				if (!rl_append(q))
					r.status = ST_FULL;
			end
			REQ_NEXT: begin
				if (rl_cnt == 0)
					r.status = ST_EMPTY;
				else begin
					r.ready_id = rl_ids[rl_head];
					rl_head = rl_head + 3'd1;
					rl_cnt = rl_cnt - 4'd1;
					if (conc_mask[r.ready_id])
						void'(rl_append(r.ready_id));
				end
			end
			REQ_POP: begin
				if (rd != wr) begin
					r.msg_out = mbox_words[q*DEPTH + rd];
					rd = rd + 10'd1;
					rd_ptr[q] = rd;
					len = wr - rd;
					if (ovl_lim[q] == 0)
						ovl_lim[q] = 11'd1;
					while ({1'b0, len} > ovl_lim[q]) begin
						ovl_val[q] = len;
						ovl_lim[q] = ovl_lim[q] << 1;
					end
				end else begin
					r.status = ST_EMPTY;
					ovl_lim[q] = (ovl_base == 0) ? 11'd1 : {1'b0, ovl_base};
					if (!conc_mask[q])
						mark[q] = 1'b0;
				end
			end
			REQ_LENGTH: r.count = wr - rd;
			REQ_TAKE_OVL: begin
				r.count = ovl_val[q];
				ovl_val[q] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic idle_burst();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic send_request(logic [2:0] kind, logic [2:0] q, logic [63:0] pay);
		in_item_t it;
		it.req_type = kind;
		it.queue_id = q;
		it.payload = pay;
		idle_burst();
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(mailbox_predict(it));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == {REG_CONCURRENT, 2'b00})
			conc_mask = val[7:0];
		else
			ovl_base = val[9:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [7:0] mask, logic [9:0] base);
		wait_drained();
		write_reg({REG_CONCURRENT, 2'b00}, {24'd0, mask});
		write_reg({REG_OVL_BASE, 2'b00}, {22'd0, base});
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected transaction %h", out_data);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_data.status);
					errors++;
				end
				if (out_data.msg_out !== e.msg_out) begin
					$error("msg_out exp %h got %h", e.msg_out, out_data.msg_out);
					errors++;
				end
				if (out_data.ready_id !== e.ready_id) begin
					$error("ready_id exp %0d got %0d", e.ready_id, out_data.ready_id);
					errors++;
				end
				if (out_data.count !== e.count) begin
					$error("count exp %0d got %0d", e.count, out_data.count);
					errors++;
				end
				if (out_data.became_ready !== e.became_ready) begin
					$error("became_ready exp %0d got %0d", e.became_ready,
						out_data.became_ready);
					errors++;
				end
			end
		end
	end

	// receiver stall bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!no_idle && !quiet_out && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		wait (cycles >= 400000);
		$display("FAILURE");
		$finish;
	end

	task automatic test_directed();
		send_request(REQ_NEXT, 3'd0, '0);
		send_request(REQ_POP, 3'd7, '0);
		send_request(REQ_PUSH, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(REQ_PUSH, 3'd0, 64'h0);
		send_request(REQ_POP, 3'd0, '0);
		send_request(REQ_PUSH, 3'd0, 64'hA5A5_5A5A_0123_4567);
		send_request(REQ_LENGTH, 3'd7, '0);
		send_request(REQ_POP, 3'd7, '0);
		send_request(REQ_POP, 3'd7, '0);
		send_request(REQ_PUSH, 3'd7, 64'h1);
		send_request(REQ_NEXT, 3'd0, '0);
		send_request(REQ_NEXT, 3'd0, '0);
		for (int i = 0; i < 9; i++)
			send_request(REQ_SCHEDULE, i[2:0], '0);
		send_request(REQ_TAKE_OVL, 3'd3, '0);
		send_request(3'd6, 3'd2, 64'h55);
		send_request(3'd7, 3'd5, 64'hAA);
		for (int i = 0; i < 9; i++)
			send_request(REQ_NEXT, 3'd0, '0);
	endtask

	// push a burst into one queue, then drain it so overload doubling fires
	task automatic test_overload(logic [2:0] q, int n);
		for (int i = 0; i < n; i++)
			send_request(REQ_PUSH, q, {$urandom, $urandom});
		send_request(REQ_LENGTH, q, '0);
		for (int i = 0; i < n + 1; i++) begin
			send_request(REQ_POP, q, '0);
			if (i % 10 == 0)
				send_request(REQ_TAKE_OVL, q, '0);
		end
		send_request(REQ_TAKE_OVL, q, '0);
	endtask

	task automatic test_random(int n);
		logic [2:0] kind;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: kind = REQ_PUSH;
				3: kind = REQ_SCHEDULE;
				4, 5: kind = REQ_NEXT;
				6, 7: kind = REQ_POP;
				8: kind = ($urandom_range(0, 1)) ? REQ_LENGTH : REQ_TAKE_OVL;
				default: kind = 3'($urandom_range(0, 7));
			endcase
			send_request(kind, 3'($urandom_range(0, 7)), {$urandom, $urandom});
		end
	endtask

	initial begin
		for (int q = 0; q < NQ; q++) begin
			rd_ptr[q] = '0;
			wr_ptr[q] = '0;
			mark[q] = 1'b1;
			ovl_val[q] = '0;
			ovl_lim[q] = 11'd256;
			rl_ids[q] = '0;
		end
		rl_head = '0;
		rl_tail = '0;
		rl_cnt = '0;
		conc_mask = '0;
		ovl_base = 10'd256;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		set_config(8'hFF, 10'd1);
		test_random(150);
		set_config(8'h00, 10'd0);
		test_random(120);
		set_config(8'h00, 10'd1023);
		test_overload(3'd4, 40);
		set_config(8'hA5, 10'd1);
		test_overload(3'd2, 40);
		set_config(8'h5A, 10'd3);
		quiet_out = 1'b1;
		test_random(150);
		wait_drained();
		quiet_out = 1'b0;
		test_random(150);
		no_idle = 1'b1;
		test_random(100);
		wait_drained();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
